// File: hdl/drpo_pkg.sv
// ----------------------------------------------------------------------------
// drpo_pkg
// Shared types, constants and font table of the decimal readout overlay.
// ----------------------------------------------------------------------------
`default_nettype none

package drpo_pkg;

   localparam int unsigned COORD_W     = 8;
   localparam int unsigned VALUE_W     = 16;
   localparam int unsigned COLOUR_W    = 8;
   localparam int unsigned CSR_INDEX_W = 8;
   localparam int unsigned CSR_DATA_W  = 8;

   // Register indexes on the configuration port
   localparam logic [CSR_INDEX_W-1:0] REG_INK_COLOUR   = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_PAPER_COLOUR = 8'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_ORIGIN_X     = 8'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_ORIGIN_Y     = 8'd3;

   localparam logic [COLOUR_W-1:0] INK_COLOUR_RESET   = 8'd1;
   localparam logic [COLOUR_W-1:0] PAPER_COLOUR_RESET = 8'd0;
   localparam logic [COORD_W-1:0]  ORIGIN_X_RESET     = 8'd2;
   localparam logic [COORD_W-1:0]  ORIGIN_Y_RESET     = 8'd2;

   // Glyph geometry
   localparam int unsigned GLYPH_W     = 4;
   localparam int unsigned GLYPH_H     = 6;
   localparam int unsigned PITCH       = 5;
   localparam int unsigned GLYPHS      = 4;
   localparam int unsigned PANEL_W     = GLYPHS * PITCH + 1;
   localparam int unsigned PANEL_H     = GLYPH_H + 2;
   localparam int unsigned GLYPH_CODES = 11;

   localparam logic [9:0] MAX_VALUE  = 10'd999;
   localparam logic [3:0] POINT_CODE = 4'd10;

   // Slot order across the panel: hundreds, tens, point, units
   localparam logic [1:0] SLOT_HUNDREDS = 2'd0;
   localparam logic [1:0] SLOT_TENS     = 2'd1;
   localparam logic [1:0] SLOT_POINT    = 2'd2;
   localparam logic [1:0] SLOT_UNITS    = 2'd3;

   // Font: one row per entry, leftmost pixel in the top bit
   localparam logic [GLYPH_W-1:0] FONT_ROM [GLYPH_CODES][GLYPH_H] = '{
      '{4'h6, 4'h9, 4'h9, 4'h9, 4'h9, 4'h6},
      '{4'h2, 4'h6, 4'h2, 4'h2, 4'h2, 4'h7},
      '{4'h6, 4'h9, 4'h1, 4'h2, 4'h4, 4'hF},
      '{4'hE, 4'h1, 4'h6, 4'h1, 4'h1, 4'hE},
      '{4'h2, 4'h6, 4'hA, 4'hF, 4'h2, 4'h2},
      '{4'hF, 4'h8, 4'hE, 4'h1, 4'h1, 4'hE},
      '{4'h6, 4'h8, 4'hE, 4'h9, 4'h9, 4'h6},
      '{4'hF, 4'h1, 4'h2, 4'h2, 4'h4, 4'h4},
      '{4'h6, 4'h9, 4'h6, 4'h9, 4'h9, 4'h6},
      '{4'h6, 4'h9, 4'h9, 4'h7, 4'h1, 4'h6},
      '{4'h0, 4'h0, 4'h0, 4'h0, 4'h0, 4'h4}
   };

   typedef struct packed {
      logic [COORD_W-1:0] pixel_x;
      logic [COORD_W-1:0] pixel_y;
      logic [VALUE_W-1:0] value_tenths;
   } req_payload_type;

endpackage

`default_nettype wire

// File: hdl/drpo_if.sv
// ----------------------------------------------------------------------------
// drpo channel interfaces
// Request, response and register-write channels with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface drpo_req_if;
   logic                         valid;
   logic                         ready;
   logic [drpo_pkg::COORD_W-1:0] pixel_x;
   logic [drpo_pkg::COORD_W-1:0] pixel_y;
   logic [drpo_pkg::VALUE_W-1:0] value_tenths;

   modport source (output valid, pixel_x, pixel_y, value_tenths, input ready);
   modport sink   (input valid, pixel_x, pixel_y, value_tenths, output ready);
endinterface

interface drpo_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          covered;
   logic [drpo_pkg::COLOUR_W-1:0] colour;

   modport source (output valid, covered, colour, input ready);
   modport sink   (input valid, covered, colour, output ready);
endinterface

interface drpo_csr_if;
   logic                             valid;
   logic                             ready;
   logic [drpo_pkg::CSR_INDEX_W-1:0] index;
   logic [drpo_pkg::CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: hdl/decimal_readout_pixel_overlay.sv
// A response passes through the request register and then the response register, and a
// stalled response can hold it in the request register between the two.
// One request is taken per cycle while the response is not stalled, set by the
// two-register pipeline (request register, then response register) with no iteration.
// A stalled response holds both stages; the request register refills as the
// response moves on. Reset (synchronous) empties both stages and loads the
// register defaults: ink 1, paper 0, origin (2, 2).
// ----------------------------------------------------------------------------
// decimal_readout_pixel_overlay
// Answers pixel queries for a "NN.N" readout panel: coverage and colour.
// ----------------------------------------------------------------------------
`default_nettype none

module decimal_readout_pixel_overlay (
   input wire logic   clock,
   input wire logic   reset,
   drpo_req_if.sink   req_bus,
   drpo_rsp_if.source rsp_bus,
   drpo_csr_if.sink   csr_bus
);
   import drpo_pkg::*;

   // ---------------------------------------------------------------------
   // Configuration registers. Writes are always taken; unknown indexes drop.
   // ---------------------------------------------------------------------
   logic [COLOUR_W-1:0] ink_colour_ff;
   logic [COLOUR_W-1:0] paper_colour_ff;
   logic [COORD_W-1:0]  origin_x_ff;
   logic [COORD_W-1:0]  origin_y_ff;

   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         ink_colour_ff   <= INK_COLOUR_RESET;
         paper_colour_ff <= PAPER_COLOUR_RESET;
         origin_x_ff     <= ORIGIN_X_RESET;
         origin_y_ff     <= ORIGIN_Y_RESET;
      end else if (csr_bus.valid) begin
         unique case (csr_bus.index)
            REG_INK_COLOUR:   ink_colour_ff   <= csr_bus.data;
            REG_PAPER_COLOUR: paper_colour_ff <= csr_bus.data;
            REG_ORIGIN_X:     origin_x_ff     <= csr_bus.data;
            REG_ORIGIN_Y:     origin_y_ff     <= csr_bus.data;
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Pipeline control. Both stages advance together unless the response
   // stage is full and not being taken.
   // ---------------------------------------------------------------------
   logic            req_valid_ff;
   req_payload_type req_ff;
   logic            rsp_valid_ff;
   logic            rsp_covered_ff;
   logic [COLOUR_W-1:0] rsp_colour_ff;

   logic advance;
   logic req_take;

   assign advance       = !rsp_valid_ff || rsp_bus.ready;
   assign req_bus.ready = !req_valid_ff || advance;
   assign req_take      = req_bus.valid && req_bus.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (req_bus.ready) begin
         req_valid_ff <= req_bus.valid;
      end
   end

   // Request payload: load on acceptance, hold otherwise
   always_ff @(posedge clock) begin
      if (req_take) begin
         req_ff.pixel_x      <= req_bus.pixel_x;
         req_ff.pixel_y      <= req_bus.pixel_y;
         req_ff.value_tenths <= req_bus.value_tenths;
      end
   end

   // ---------------------------------------------------------------------
   // Panel geometry: offsets from the panel's top-left corner, which sits
   // one pixel left of and above the first glyph. Coordinates wrap at 256.
   // ---------------------------------------------------------------------
   logic [COORD_W-1:0] dx;
   logic [COORD_W-1:0] dy;
   logic               covered_in;
   logic               in_glyph_band;
   logic [4:0]         gx;
   logic [2:0]         row;
   logic [7:0]         slot_prod;
   logic [1:0]         slot;
   logic [4:0]         slot_x5;
   logic [2:0]         col;

   assign dx = req_ff.pixel_x + COORD_W'(1) - origin_x_ff;
   assign dy = req_ff.pixel_y + COORD_W'(1) - origin_y_ff;

   assign covered_in = (dx < COORD_W'(PANEL_W)) && (dy < COORD_W'(PANEL_H));

   // Inside the panel dx is below 21, so five bits of it suffice
   assign in_glyph_band = (dx != '0) && (dy != '0) && (dy <= COORD_W'(GLYPH_H));
   assign gx  = dx[4:0] - 5'd1;
   assign row = dy[2:0] - 3'd1;

   // Divide the glyph column by the pitch: x*13/64 is exact for x below 20
   assign slot_prod = 8'(gx) * 8'd13;
   assign slot      = slot_prod[7:6];
   assign slot_x5   = 5'(slot) * 5'd5;
   assign col       = 3'(gx - slot_x5);

   // ---------------------------------------------------------------------
   // Digits of the saturated value. Reciprocal multiplies stand in for the
   // constant divisions: v*41/4096 = v/100 for v up to 999, r*205/2048 =
   // r/10 for r up to 99.
   // ---------------------------------------------------------------------
   logic [9:0]  value_sat;
   logic [15:0] hund_prod;
   logic [3:0]  hundreds;
   logic [9:0]  hund_x100;
   logic [6:0]  rem_hund;
   logic [14:0] tens_prod;
   logic [3:0]  tens;
   logic [6:0]  tens_x10;
   logic [3:0]  units;

   assign value_sat = (req_ff.value_tenths > VALUE_W'(MAX_VALUE)) ?
                      MAX_VALUE : req_ff.value_tenths[9:0];
   assign hund_prod = 16'(value_sat) * 16'd41;
   assign hundreds  = hund_prod[15:12];
   assign hund_x100 = 10'(hundreds) * 10'd100;
   assign rem_hund  = 7'(value_sat - hund_x100);
   assign tens_prod = 15'(rem_hund) * 15'd205;
   assign tens      = tens_prod[14:11];
   assign tens_x10  = 7'(tens) * 7'd10;
   assign units     = 4'(rem_hund - tens_x10);

   // ---------------------------------------------------------------------
   // Glyph lookup and colour choice
   // ---------------------------------------------------------------------
   logic [3:0]         glyph_code;
   logic [GLYPH_W-1:0] glyph_bits;
   logic               lit;
   logic [COLOUR_W-1:0] colour_in;

   always_comb begin
      unique case (slot)
         SLOT_HUNDREDS: glyph_code = hundreds;
         SLOT_TENS:     glyph_code = tens;
         SLOT_POINT:    glyph_code = POINT_CODE;
         SLOT_UNITS:    glyph_code = units;
      endcase
   end

   assign glyph_bits = FONT_ROM[glyph_code][row];

   // Leftmost column reads the top bit; the gap column between glyphs is never lit
   assign lit = in_glyph_band && (col < 3'(GLYPH_W)) &&
                glyph_bits[2'(3'(GLYPH_W - 1) - col)];

   always_comb begin
      priority if (!covered_in) begin
         colour_in = '0;
      end else if (lit) begin
         colour_in = ink_colour_ff;
      end else begin
         colour_in = paper_colour_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Response register
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= req_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && req_valid_ff) begin
         rsp_covered_ff <= covered_in;
         rsp_colour_ff  <= colour_in;
      end
   end

   assign rsp_bus.valid   = rsp_valid_ff;
   assign rsp_bus.covered = rsp_covered_ff;
   assign rsp_bus.colour  = rsp_colour_ff;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   a_reset_empties: assert property (@(posedge clock)
      reset |=> !req_valid_ff && !rsp_valid_ff)
      else $error("pipeline not empty after reset");

   a_take_fills: assert property (@(posedge clock) disable iff (reset)
      req_take |=> req_valid_ff)
      else $error("accepted request lost from request stage");

   a_stage_moves: assert property (@(posedge clock) disable iff (reset)
      req_valid_ff && advance |=> rsp_valid_ff)
      else $error("request stage advanced without filling response stage");

   a_stage_holds: assert property (@(posedge clock) disable iff (reset)
      req_valid_ff && !advance |=> req_valid_ff && $stable(req_ff))
      else $error("stalled request stage changed");

   a_uncovered_dark: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_covered_ff |-> rsp_colour_ff == '0)
      else $error("uncovered pixel with non-zero colour");

endmodule

`default_nettype wire

// File: tb/decimal_readout_pixel_overlay_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// decimal_readout_pixel_overlay_test
// Self-checking bench for the readout overlay. Sends pixel requests under a
// series of colour and origin settings, works out panel coverage and colour
// for each one independently, and checks every response in order.
// ----------------------------------------------------------------------------

module decimal_readout_pixel_overlay_test;

   localparam int CLOCK_HALF     = 2;
   localparam int RESET_CYCLES   = 7;
   localparam int DRAIN_CYCLES   = 6;      // pipeline is two deep; allow some slack
   localparam int CYCLE_LIMIT    = 200000;
   localparam int PHASE_REQUESTS = 205;
   localparam int MAX_WAIT       = 10;
   localparam int REPORT_LIMIT   = 10;

   // Panel geometry, as seen from the panel's top-left corner
   localparam int PANEL_COLUMNS = 21;
   localparam int PANEL_ROWS    = 8;
   localparam int CELL_COLUMNS  = 4;
   localparam int CELL_ROWS     = 6;
   localparam int CELL_PITCH    = 5;
   localparam int CELL_COUNT    = 4;
   localparam int SATURATION    = 999;
   localparam int DOT_GLYPH     = 10;

   // Indexes that map to no register; writes there must change nothing
   localparam logic [drpo_pkg::CSR_INDEX_W-1:0] REG_UNMAPPED_FIRST = 8'd4;
   localparam logic [drpo_pkg::CSR_INDEX_W-1:0] REG_UNMAPPED_LAST  = 8'hFF;

   typedef enum int {
      HUNDREDS_CELL = 0,
      TENS_CELL     = 1,
      DOT_CELL      = 2,
      UNITS_CELL    = 3
   } readout_slot_type;

   typedef struct packed {
      logic                           covered;
      logic [drpo_pkg::COLOUR_W-1:0]  colour;
   } overlay_pixel_type;

   logic clock;
   logic reset = 1'b1;

   // Everything the bench drives starts at a known value
   logic                               req_valid = 1'b0;
   drpo_pkg::req_payload_type          req_item  = '0;
   logic                               rsp_ready = 1'b0;
   logic                               csr_valid = 1'b0;
   logic [drpo_pkg::CSR_INDEX_W-1:0]   csr_index = '0;
   logic [drpo_pkg::CSR_DATA_W-1:0]    csr_data  = '0;

   // Register copies used for prediction
   logic [7:0] ink_shadow      = drpo_pkg::INK_COLOUR_RESET;
   logic [7:0] paper_shadow    = drpo_pkg::PAPER_COLOUR_RESET;
   logic [7:0] origin_x_shadow = drpo_pkg::ORIGIN_X_RESET;
   logic [7:0] origin_y_shadow = drpo_pkg::ORIGIN_Y_RESET;

   drpo_pkg::req_payload_type pending_queries[$];
   overlay_pixel_type         expected_pixels[$];
   overlay_pixel_type         oldest_pixel;

   int queries_queued   = 0;
   int responses_seen   = 0;
   int failures         = 0;
   int cycle_count      = 0;
   int req_gap          = 0;
   int req_stretch      = 0;
   bit req_calm         = 1'b0;
   int rsp_hold         = 0;
   int rsp_stretch      = 0;
   bit rsp_calm         = 1'b0;

   drpo_req_if req_bus ();
   drpo_rsp_if rsp_bus ();
   drpo_csr_if csr_bus ();

   assign req_bus.valid        = req_valid;
   assign req_bus.pixel_x      = req_item.pixel_x;
   assign req_bus.pixel_y      = req_item.pixel_y;
   assign req_bus.value_tenths = req_item.value_tenths;
   assign rsp_bus.ready        = rsp_ready;
   assign csr_bus.valid        = csr_valid;
   assign csr_bus.index        = csr_index;
   assign csr_bus.data         = csr_data;

   decimal_readout_pixel_overlay dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   initial begin
      clock = 1'b0;
      forever #CLOCK_HALF clock = ~clock;
   end

   // Font bitmaps: six rows of four pixels, top row in the high nibble and the
   // leftmost pixel of each row in the nibble's top bit.
   function automatic logic [23:0] glyph_bitmap(input int code);
      case (code)
         0:         return 24'h699996;
         1:         return 24'h262227;
         2:         return 24'h69124F;
         3:         return 24'hE1611E;
         4:         return 24'h26AF22;
         5:         return 24'hF8E11E;
         6:         return 24'h68E996;
         7:         return 24'hF12244;
         8:         return 24'h696996;
         9:         return 24'h699716;
         DOT_GLYPH: return 24'h000004;
         default:   return 24'h000000;
      endcase
   endfunction

   // Work out coverage and colour of one pixel under the current settings.
   function automatic overlay_pixel_type shade_pixel(input drpo_pkg::req_payload_type q);
      logic [7:0]        dx;
      logic [7:0]        dy;
      int                shown;
      int                gx;
      int                slot;
      int                column;
      int                row;
      int                code;
      logic [23:0]       glyph;
      overlay_pixel_type result;
      // Offsets from the panel corner, one pixel up-left of the origin; wrap at 256
      dx     = q.pixel_x + 8'd1 - origin_x_shadow;
      dy     = q.pixel_y + 8'd1 - origin_y_shadow;
      shown  = (q.value_tenths > SATURATION) ? SATURATION : int'(q.value_tenths);
      result = '0;
      if (dx < PANEL_COLUMNS && dy < PANEL_ROWS) begin
         result.covered = 1'b1;
         result.colour  = paper_shadow;
         if (dx >= 1 && dy >= 1 && dy <= CELL_ROWS) begin
            gx     = dx - 1;
            slot   = gx / CELL_PITCH;
            column = gx % CELL_PITCH;
            row    = dy - 1;
            if (slot < CELL_COUNT && column < CELL_COLUMNS) begin
               case (slot)
                  HUNDREDS_CELL: code = shown / 100;
                  TENS_CELL:     code = (shown / 10) % 10;
                  DOT_CELL:      code = DOT_GLYPH;
                  default:       code = shown % 10;
               endcase
               glyph = glyph_bitmap(code);
               if (glyph[23 - 4 * row - column]) begin
                  result.colour = ink_shadow;
               end
            end
         end
      end
      return result;
   endfunction

   // Draw a wait for the next request or response; spells of no waiting come and go.
   function automatic int draw_wait(inout int stretch_left, inout bit calm);
      if (stretch_left == 0) begin
         calm         = ($urandom_range(0, 3) == 0);
         stretch_left = $urandom_range(8, 40);
      end
      stretch_left--;
      return calm ? 0 : $urandom_range(0, MAX_WAIT);
   endfunction

   function automatic drpo_pkg::req_payload_type make_query(input logic [7:0] x,
                                                            input logic [7:0] y,
                                                            input logic [15:0] value);
      drpo_pkg::req_payload_type q;
      q.pixel_x      = x;
      q.pixel_y      = y;
      q.value_tenths = value;
      return q;
   endfunction

   // Mostly aim at the panel and just around it; the rest lands anywhere.
   function automatic drpo_pkg::req_payload_type random_query();
      int                        pick;
      drpo_pkg::req_payload_type q;
      if ($urandom_range(0, 9) < 7) begin
         q.pixel_x = origin_x_shadow - 8'd2 + 8'($urandom_range(0, PANEL_COLUMNS + 2));
         q.pixel_y = origin_y_shadow - 8'd2 + 8'($urandom_range(0, PANEL_ROWS + 2));
      end else begin
         q.pixel_x = 8'($urandom);
         q.pixel_y = 8'($urandom);
      end
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
         q.value_tenths = 16'($urandom_range(0, SATURATION));
      end else if (pick == 7) begin
         q.value_tenths = 16'($urandom_range(SATURATION - 4, SATURATION + 6));
      end else begin
         q.value_tenths = 16'($urandom);
      end
      return q;
   endfunction

   // Request driver: hold a request until taken, then idle for the drawn gap
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_bus.ready) begin
            expected_pixels.push_back(shade_pixel(req_item));
         end
         if (!req_valid || req_bus.ready) begin
            if (req_gap > 0) begin
               req_gap--;
               req_valid <= 1'b0;
            end else if (pending_queries.size() != 0) begin
               req_item  <= pending_queries.pop_front();
               req_valid <= 1'b1;
               req_gap    = draw_wait(req_stretch, req_calm);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Response monitor: compare against the oldest prediction, then stall at random
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_ready) begin
            responses_seen++;
            if (expected_pixels.size() == 0) begin
               failures++;
               if (failures <= REPORT_LIMIT) begin
                  $display("[%0t] response with nothing outstanding: covered %0b colour %0d",
                           $realtime, rsp_bus.covered, rsp_bus.colour);
               end
            end else begin
               oldest_pixel = expected_pixels.pop_front();
               if (rsp_bus.covered !== oldest_pixel.covered ||
                   rsp_bus.colour !== oldest_pixel.colour) begin
                  failures++;
                  if (failures <= REPORT_LIMIT) begin
                     $display({"[%0t] response %0d: expected covered %0b colour %0d,",
                               " got covered %0b colour %0d"},
                              $realtime, responses_seen, oldest_pixel.covered,
                              oldest_pixel.colour, rsp_bus.covered, rsp_bus.colour);
                  end
               end
            end
            rsp_hold = draw_wait(rsp_stretch, rsp_calm);
         end
         if (rsp_hold > 0) begin
            rsp_hold--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Watchdog: give up well beyond the slowest legitimate run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d of %0d responses seen",
                  cycle_count, responses_seen, queries_queued);
         $display("== FAIL ==");
         $finish;
      end
   end

   // Write one register and update the prediction copy once it is taken.
   task automatic write_register(input logic [drpo_pkg::CSR_INDEX_W-1:0] index,
                                 input logic [drpo_pkg::CSR_DATA_W-1:0]  data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      do @(posedge clock); while (!csr_bus.ready);
      csr_valid <= 1'b0;
      case (index)
         drpo_pkg::REG_INK_COLOUR:   ink_shadow      = data;
         drpo_pkg::REG_PAPER_COLOUR: paper_shadow    = data;
         drpo_pkg::REG_ORIGIN_X:     origin_x_shadow = data;
         drpo_pkg::REG_ORIGIN_Y:     origin_y_shadow = data;
         default: ;
      endcase
   endtask

   task automatic apply_setting(input logic [7:0] ink, input logic [7:0] paper,
                                input logic [7:0] x, input logic [7:0] y);
      write_register(drpo_pkg::REG_INK_COLOUR, ink);
      write_register(drpo_pkg::REG_PAPER_COLOUR, paper);
      write_register(drpo_pkg::REG_ORIGIN_X, x);
      write_register(drpo_pkg::REG_ORIGIN_Y, y);
   endtask

   task automatic queue_query(input drpo_pkg::req_payload_type q);
      pending_queries.push_back(q);
      queries_queued++;
   endtask

   // Wait until every queued request has been answered, then let the pipe settle
   task automatic wait_until_drained();
      do @(posedge clock); while (responses_seen < queries_queued);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic run_random_phase();
      for (int i = 0; i < PHASE_REQUESTS; i++) begin
         queue_query(random_query());
      end
      wait_until_drained();
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Directed requests under the reset settings: panel spans (1,1) to (21,8)
      queue_query(make_query(8'd0,   8'd0,   16'd0));      // outside, top-left
      queue_query(make_query(8'd255, 8'd255, 16'hFFFF));   // outside, all ones
      queue_query(make_query(8'd1,   8'd1,   16'd0));      // panel corner, paper
      queue_query(make_query(8'd21,  8'd8,   16'd0));      // far panel corner
      queue_query(make_query(8'd22,  8'd8,   16'd0));      // one past the right edge
      queue_query(make_query(8'd21,  8'd9,   16'd0));      // one past the bottom edge
      queue_query(make_query(8'd1,   8'd4,   16'd555));    // left margin
      queue_query(make_query(8'd3,   8'd8,   16'd888));    // bottom margin under a glyph
      queue_query(make_query(8'd2,   8'd2,   16'd0));      // unlit glyph pixel
      queue_query(make_query(8'd3,   8'd2,   16'd0));      // lit glyph pixel
      queue_query(make_query(8'd2,   8'd3,   16'd999));    // largest shown value
      queue_query(make_query(8'd2,   8'd3,   16'd1000));   // saturates to 99.9
      queue_query(make_query(8'd2,   8'd3,   16'hFFFF));   // saturates from the top
      queue_query(make_query(8'd5,   8'd4,   16'h7FFF));
      queue_query(make_query(8'd4,   8'd5,   16'h8000));
      queue_query(make_query(8'd7,   8'd3,   16'd50));     // tens digit, lit
      queue_query(make_query(8'd6,   8'd3,   16'd50));     // gap between glyphs
      queue_query(make_query(8'd13,  8'd7,   16'd123));    // decimal point, lit
      queue_query(make_query(8'd12,  8'd7,   16'd123));    // beside the point
      queue_query(make_query(8'd17,  8'd2,   16'd8));      // units digit, unlit
      queue_query(make_query(8'd18,  8'd2,   16'd8));      // units digit, lit
      queue_query(make_query(8'd20,  8'd7,   16'd7));      // last glyph column, last row
      wait_until_drained();

      // Lowest origin, full ink on zero paper
      apply_setting(8'hFF, 8'h00, 8'd1, 8'd1);
      run_random_phase();

      // A high origin still clear of the edge, colours swapped
      apply_setting(8'h00, 8'hFF, 8'd234, 8'd248);
      run_random_phase();

      // Origin at zero: panel wraps round to column and row 255; unmapped writes drop
      apply_setting(8'hA5, 8'h5A, 8'd0, 8'd0);
      write_register(REG_UNMAPPED_FIRST, 8'h3C);
      write_register(REG_UNMAPPED_LAST, 8'hFF);
      run_random_phase();

      // Panel straddling both edges
      apply_setting(8'($urandom), 8'($urandom), 8'd250, 8'd255);
      run_random_phase();

      // Anything goes
      apply_setting(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
      run_random_phase();

      if (failures == 0 && expected_pixels.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
